[hdl/nglc_pkg.sv]
// ----------------------------------------------------------------------------
// nglc_pkg
// Shared codes and constants for the nearest grid cell locator.
// ----------------------------------------------------------------------------
package nglc_pkg;

    localparam logic [1:0] OP_LOAD_LON = 2'd0;
    localparam logic [1:0] OP_LOAD_LAT = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    localparam logic CFG_LON_COUNT = 1'b0;
    localparam logic CFG_LAT_COUNT = 1'b1;

    localparam int LON_W   = 27;
    localparam int LAT_W   = 24;
    localparam int CFG_W   = 11;
    localparam int LONCNT_W = 11;
    localparam int LATCNT_W = 10;

    // 360 degrees in Q.16 and its multiples used for the modulo reduction
    localparam logic [27:0] TURN_X1 = 28'd23592960;
    localparam logic [27:0] TURN_X2 = 28'd47185920;
    localparam logic [27:0] TURN_X4 = 28'd94371840;

endpackage

[hdl/nglc_ram.sv]
// ----------------------------------------------------------------------------
// nglc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module nglc_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/nearest_grid_cell_locator_core.sv]
// ----------------------------------------------------------------------------
// nearest_grid_cell_locator_core
// Nearest grid point search over a longitude axis (periodic) and a latitude
// axis held in two axis memories.
// ----------------------------------------------------------------------------
// A load word (op 0 or 1) or an unused word (op 3) is taken while idle and
// busy stays low. A query word (op 2) holds busy high through the sweep of
// max(lon_count, lat_count) entries, each count taken as at least one and at
// most its store depth: both axis memories are swept in parallel through
// their single read port, one entry per cycle, and then through memory read,
// distance pipeline, compare and result register. The result is shown for one
// cycle on done; the receiver cannot stall it, busy is already low in that
// cycle and a new word may be taken then.
// ----------------------------------------------------------------------------
module nearest_grid_cell_locator_core #(
    parameter int MAX_LON_POINTS = 1024,
    parameter int MAX_LAT_POINTS = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [9:0]                   position,
    input  logic signed [26:0]           coord_a,
    input  logic signed [23:0]           coord_b,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [nglc_pkg::CFG_W-1:0]   cfg_data,
    output logic                         done,
    output logic [9:0]                   lon_index,
    output logic [8:0]                   lat_index,
    output logic [18:0]                  flat_index,
    output logic signed [26:0]           grid_lon,
    output logic signed [23:0]           grid_lat
);

    localparam int MAX_PTS = (MAX_LON_POINTS > MAX_LAT_POINTS) ? MAX_LON_POINTS
                                                               : MAX_LAT_POINTS;
    localparam int IW     = (MAX_PTS > 1) ? $clog2(MAX_PTS) : 1;
    localparam int CW     = $clog2(MAX_PTS + 1);
    localparam int LON_AW = (MAX_LON_POINTS > 1) ? $clog2(MAX_LON_POINTS) : 1;
    localparam int LAT_AW = (MAX_LAT_POINTS > 1) ? $clog2(MAX_LAT_POINTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    typedef struct packed {
        logic                          act;
        logic                          last;
        logic                          lon_v;
        logic                          lat_v;
        logic [IW-1:0]                 idx;
        logic [nglc_pkg::LON_W-1:0]    lon_val;
        logic [nglc_pkg::LAT_W-1:0]    lat_val;
        logic [24:0]                   lat_d;
    } carry_t;

    // configuration
    logic [nglc_pkg::LONCNT_W-1:0] lon_count_reg;
    logic [nglc_pkg::LATCNT_W-1:0] lat_count_reg;

    // control
    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] nlon_reg, nlat_reg, nmax_reg;
    logic [CW-1:0] nlon_next, nlat_next;
    logic [31:0]   nlon_w, nlat_w;
    logic signed [26:0] q_lon_reg;
    logic signed [23:0] q_lat_reg;

    logic accept, query_go, issue, issue_last;
    logic [31:0] pos_ext;

    // memories
    logic                       lon_we, lat_we;
    logic [LON_AW-1:0]          lon_waddr, lon_raddr;
    logic [LAT_AW-1:0]          lat_waddr, lat_raddr;
    logic [nglc_pkg::LON_W-1:0] lon_rdata;
    logic [nglc_pkg::LAT_W-1:0] lat_rdata;

    // pipeline
    logic          p1_act_reg, p1_last_reg, p1_lon_v_reg, p1_lat_v_reg;
    logic [IW-1:0] p1_idx_reg;
    carry_t        c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c2_next;
    logic [27:0]   ld2_reg, ld3_reg, ld4_reg, ld2_next, ld3_next, ld4_next;
    logic [24:0]   ld5_reg, ld5_next, dist6_reg, dist6_next;
    logic signed [27:0] lon_sd;
    logic signed [24:0] lat_sd;
    logic [27:0]   ld5_full;
    logic [24:0]   wrap_d;

    // best so far
    logic          lon_have_reg, lat_have_reg;
    logic [IW-1:0] best_lon_idx_reg, best_lat_idx_reg;
    logic [24:0]   best_lon_d_reg, best_lat_d_reg;
    logic [nglc_pkg::LON_W-1:0] best_lon_val_reg;
    logic [nglc_pkg::LAT_W-1:0] best_lat_val_reg;
    logic          lon_upd, lat_upd;

    // result
    logic          done_reg;
    logic [9:0]    lon_index_reg;
    logic [8:0]    lat_index_reg;
    logic [18:0]   flat_index_reg;
    logic signed [26:0] grid_lon_reg;
    logic signed [23:0] grid_lat_reg;
    logic [31:0]   bi_ext, bj_ext, flat_w;

    // ---------------------------------------------------------------- input
    assign accept   = start && (state_reg == ST_IDLE);
    assign query_go = accept && (op == nglc_pkg::OP_QUERY);
    assign pos_ext  = {22'd0, position};

    assign lon_we    = accept && (op == nglc_pkg::OP_LOAD_LON)
                       && (pos_ext < 32'(MAX_LON_POINTS));
    assign lat_we    = accept && (op == nglc_pkg::OP_LOAD_LAT)
                       && (pos_ext < 32'(MAX_LAT_POINTS));
    assign lon_waddr = pos_ext[LON_AW-1:0];
    assign lat_waddr = pos_ext[LAT_AW-1:0];
    assign lon_raddr = idx_reg[LON_AW-1:0];
    assign lat_raddr = idx_reg[LAT_AW-1:0];

    nglc_ram #(.WIDTH(nglc_pkg::LON_W), .DEPTH(MAX_LON_POINTS)) u_lon_ram (
        .clk   (clk),
        .we    (lon_we),
        .waddr (lon_waddr),
        .wdata (coord_a),
        .raddr (lon_raddr),
        .rdata (lon_rdata)
    );

    nglc_ram #(.WIDTH(nglc_pkg::LAT_W), .DEPTH(MAX_LAT_POINTS)) u_lat_ram (
        .clk   (clk),
        .we    (lat_we),
        .waddr (lat_waddr),
        .wdata (coord_a[23:0]),
        .raddr (lat_raddr),
        .rdata (lat_rdata)
    );

    // effective counts: zero reads as one, saturate at store depth
    always_comb
    begin
        nlon_w = 32'(lon_count_reg);
        nlat_w = 32'(lat_count_reg);
        if (nlon_w == 32'd0)
        begin
            nlon_w = 32'd1;
        end
        else if (nlon_w > 32'(MAX_LON_POINTS))
        begin
            nlon_w = 32'(MAX_LON_POINTS);
        end
        if (nlat_w == 32'd0)
        begin
            nlat_w = 32'd1;
        end
        else if (nlat_w > 32'(MAX_LAT_POINTS))
        begin
            nlat_w = 32'(MAX_LAT_POINTS);
        end
        nlon_next = nlon_w[CW-1:0];
        nlat_next = nlat_w[CW-1:0];
    end

    // ---------------------------------------------------------------- control
    assign issue      = (state_reg == ST_SCAN);
    assign issue_last = (CW'(idx_reg) == (nmax_reg - CW'(1)));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (query_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + IW'(1);
                if (issue_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (c6_reg.act && c6_reg.last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            lon_count_reg <= nglc_pkg::LONCNT_W'(1);
            lat_count_reg <= nglc_pkg::LATCNT_W'(1);
            p1_act_reg    <= 1'b0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            c4_reg        <= '0;
            c5_reg        <= '0;
            c6_reg        <= '0;
            lon_have_reg  <= 1'b0;
            lat_have_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            p1_act_reg <= issue;
            c2_reg     <= c2_next;
            c3_reg     <= c2_reg;
            c4_reg     <= c3_reg;
            c5_reg     <= c4_reg;
            c6_reg     <= c5_reg;
            done_reg   <= (state_reg == ST_FIN);
            if (cfg_we && (cfg_index == nglc_pkg::CFG_LON_COUNT))
            begin
                lon_count_reg <= cfg_data[nglc_pkg::LONCNT_W-1:0];
            end
            if (cfg_we && (cfg_index == nglc_pkg::CFG_LAT_COUNT))
            begin
                lat_count_reg <= cfg_data[nglc_pkg::LATCNT_W-1:0];
            end
            if (query_go)
            begin
                lon_have_reg <= 1'b0;
                lat_have_reg <= 1'b0;
            end
            else
            begin
                if (lon_upd)
                begin
                    lon_have_reg <= 1'b1;
                end
                if (lat_upd)
                begin
                    lat_have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            nlon_reg  <= nlon_next;
            nlat_reg  <= nlat_next;
            nmax_reg  <= (nlon_next > nlat_next) ? nlon_next : nlat_next;
            q_lon_reg <= coord_a;
            q_lat_reg <= coord_b;
        end
    end

    // ---------------------------------------------------------------- pipeline
    always_comb
    begin
        lon_sd = {lon_rdata[26], lon_rdata} - {q_lon_reg[26], q_lon_reg};
        lat_sd = {lat_rdata[23], lat_rdata} - {q_lat_reg[23], q_lat_reg};

        c2_next.act     = p1_act_reg;
        c2_next.last    = p1_last_reg;
        c2_next.lon_v   = p1_lon_v_reg;
        c2_next.lat_v   = p1_lat_v_reg;
        c2_next.idx     = p1_idx_reg;
        c2_next.lon_val = lon_rdata;
        c2_next.lat_val = lat_rdata;
        c2_next.lat_d   = lat_sd[24] ? 25'(-lat_sd) : 25'(lat_sd);
        ld2_next        = lon_sd[27] ? 28'(-lon_sd) : 28'(lon_sd);

        ld3_next = (ld2_reg >= nglc_pkg::TURN_X4) ? ld2_reg - nglc_pkg::TURN_X4 : ld2_reg;
        ld4_next = (ld3_reg >= nglc_pkg::TURN_X2) ? ld3_reg - nglc_pkg::TURN_X2 : ld3_reg;
        ld5_full = (ld4_reg >= nglc_pkg::TURN_X1) ? ld4_reg - nglc_pkg::TURN_X1 : ld4_reg;
        ld5_next = ld5_full[24:0];

        wrap_d     = nglc_pkg::TURN_X1[24:0] - ld5_reg;
        dist6_next = (wrap_d < ld5_reg) ? wrap_d : ld5_reg;
    end

    always_ff @(posedge clk)
    begin
        p1_last_reg  <= issue_last;
        p1_idx_reg   <= idx_reg;
        p1_lon_v_reg <= (CW'(idx_reg) < nlon_reg);
        p1_lat_v_reg <= (CW'(idx_reg) < nlat_reg);

        ld2_reg   <= ld2_next;
        ld3_reg   <= ld3_next;
        ld4_reg   <= ld4_next;
        ld5_reg   <= ld5_next;
        dist6_reg <= dist6_next;
    end

    // ---------------------------------------------------------------- best
    // strict compare keeps the lowest index on a tie
    assign lon_upd = c6_reg.act && c6_reg.lon_v
                     && (!lon_have_reg || (dist6_reg < best_lon_d_reg));
    assign lat_upd = c6_reg.act && c6_reg.lat_v
                     && (!lat_have_reg || (c6_reg.lat_d < best_lat_d_reg));

    always_ff @(posedge clk)
    begin
        if (lon_upd)
        begin
            best_lon_d_reg   <= dist6_reg;
            best_lon_idx_reg <= c6_reg.idx;
            best_lon_val_reg <= c6_reg.lon_val;
        end
        if (lat_upd)
        begin
            best_lat_d_reg   <= c6_reg.lat_d;
            best_lat_idx_reg <= c6_reg.idx;
            best_lat_val_reg <= c6_reg.lat_val;
        end
    end

    // ---------------------------------------------------------------- result
    assign bi_ext = 32'(best_lon_idx_reg);
    assign bj_ext = 32'(best_lat_idx_reg);
    assign flat_w = bj_ext * 32'(nlon_reg) + bi_ext;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN)
        begin
            lon_index_reg  <= bi_ext[9:0];
            lat_index_reg  <= bj_ext[8:0];
            flat_index_reg <= flat_w[18:0];
            grid_lon_reg   <= best_lon_val_reg;
            grid_lat_reg   <= best_lat_val_reg;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign lon_index  = lon_index_reg;
    assign lat_index  = lat_index_reg;
    assign flat_index = flat_index_reg;
    assign grid_lon   = grid_lon_reg;
    assign grid_lat   = grid_lat_reg;

endmodule

[hdl/nglc_checker.sv]
// ----------------------------------------------------------------------------
// nglc_checker
// Port-level checks for the nearest grid cell locator.
// ----------------------------------------------------------------------------
module nglc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] op,
    input logic       done
);

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == nglc_pkg::OP_QUERY)) |=> busy)
        else $error("query word did not raise busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != nglc_pkg::OP_QUERY)) |=> !busy)
        else $error("non-query word raised busy");

    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query ended without a result word");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result word outside the end of a query");

endmodule

bind nearest_grid_cell_locator_core nglc_checker u_nglc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done)
);

[verif/nglc_cell_checker.sv]
// ----------------------------------------------------------------------------
// nglc_cell_checker
// Watches the command, config and result ports of the nearest grid cell
// locator. It keeps its own copy of both axis stores and of the counts, works
// out the nearest cell for every accepted query word and compares each
// result, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nglc_cell_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [1:0]                     op,
    input  logic [9:0]                     position,
    input  logic signed [26:0]             coord_a,
    input  logic signed [23:0]             coord_b,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [nglc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           done,
    input  logic [9:0]                     lon_index,
    input  logic [8:0]                     lat_index,
    input  logic [18:0]                    flat_index,
    input  logic signed [26:0]             grid_lon,
    input  logic signed [23:0]             grid_lat,
    output int                             pending,
    output int                             fail_count
);

    localparam int     LON_DEPTH = 1024;
    localparam int     LAT_DEPTH = 512;
    localparam longint FULL_TURN = 64'sd23592960;

    typedef struct packed {
        logic [9:0]         lon_index;
        logic [8:0]         lat_index;
        logic [18:0]        flat_index;
        logic signed [26:0] grid_lon;
        logic signed [23:0] grid_lat;
    } cell_t;

    logic signed [nglc_pkg::LON_W-1:0]  lon_points [LON_DEPTH];
    logic signed [nglc_pkg::LAT_W-1:0]  lat_points [LAT_DEPTH];
    logic [nglc_pkg::LONCNT_W-1:0]      lon_cnt;
    logic [nglc_pkg::LATCNT_W-1:0]      lat_cnt;
    cell_t                              cell_q [$];
    int                                 mismatches;

    function automatic longint span(longint x, longint y);
        return (x >= y) ? x - y : y - x;
    endfunction

    function automatic cell_t locate_cell(logic signed [26:0] site_lon,
                                          logic signed [23:0] site_lat);
        int     nlon;
        int     nlat;
        int     bi;
        int     bj;
        longint best;
        longint d;
        longint e;
        cell_t  c;
        nlon = (lon_cnt == 0) ? 1 : ((lon_cnt > LON_DEPTH) ? LON_DEPTH : int'(lon_cnt));
        nlat = (lat_cnt == 0) ? 1 : ((lat_cnt > LAT_DEPTH) ? LAT_DEPTH : int'(lat_cnt));
        bi = 0;
        bj = 0;
        best = 64'sh7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < nlon; i++) begin
            d = span(site_lon, lon_points[i]) % FULL_TURN;
            e = FULL_TURN - d;
            if (e < d)
                d = e;
            if (d < best) begin
                best = d;
                bi = i;
            end
        end
        best = 64'sh7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < nlat; i++) begin
            d = span(lat_points[i], site_lat);
            if (d < best) begin
                best = d;
                bj = i;
            end
        end
        c.lon_index  = bi[9:0];
        c.lat_index  = bj[8:0];
        c.flat_index = 19'(bj * nlon + bi);
        c.grid_lon   = lon_points[bi];
        c.grid_lat   = lat_points[bj];
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_t want;
        cell_t got;
        if (!rst_n)
        begin
            cell_q.delete();
            lon_cnt = 1;
            lat_cnt = 1;
            mismatches = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{lon_index, lat_index, flat_index, grid_lon, grid_lat};
                if (cell_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: lon %0d lat %0d flat %0d",
                                 lon_index, lat_index, flat_index);
                    mismatches++;
                end
                else
                begin
                    want = cell_q.pop_front();
                    if (got.lon_index !== want.lon_index ||
                        got.lat_index !== want.lat_index ||
                        got.flat_index !== want.flat_index ||
                        got.grid_lon !== want.grid_lon ||
                        got.grid_lat !== want.grid_lat)
                    begin
                        if (mismatches < 10)
                            $display({"result mismatch: expected lon %0d lat %0d flat %0d ",
                                      "glon %0d glat %0d, got lon %0d lat %0d flat %0d ",
                                      "glon %0d glat %0d"},
                                     want.lon_index, want.lat_index, want.flat_index,
                                     want.grid_lon, want.grid_lat,
                                     got.lon_index, got.lat_index, got.flat_index,
                                     got.grid_lon, got.grid_lat);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == nglc_pkg::CFG_LON_COUNT)
                    lon_cnt = cfg_data[nglc_pkg::LONCNT_W-1:0];
                else
                    lat_cnt = cfg_data[nglc_pkg::LATCNT_W-1:0];
            end
            if (start && !busy)
            begin
                case (op)
                    nglc_pkg::OP_LOAD_LON: lon_points[position] = coord_a;
                    nglc_pkg::OP_LOAD_LAT:
                        if (position < LAT_DEPTH)
                            lat_points[position[8:0]] = coord_a[23:0];
                    nglc_pkg::OP_QUERY: cell_q.push_back(locate_cell(coord_a, coord_b));
                    default: ;
                endcase
            end
            pending <= cell_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

[verif/nearest_grid_cell_locator_core_tb.sv]
// ----------------------------------------------------------------------------
// nearest_grid_cell_locator_core_tb
// Drives load, query and unused command words plus count writes into the
// nearest grid cell locator, in bursts with random gaps, across a series of
// count settings starting at zero. Only entries that were written are ever
// searched. The checker beside the block predicts and compares every result
// word.
// ----------------------------------------------------------------------------
module nearest_grid_cell_locator_core_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LON_LO    = -23592960;
    localparam int LON_HI    = 47185920;
    localparam int LAT_LIM   = 5898240;
    localparam int TURN      = 23592960;
    localparam int HALF_TURN = 11796480;
    localparam int LIMIT     = 500000;
    localparam int NPHASE    = 11;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     op;
    logic [9:0]                     position;
    logic signed [26:0]             coord_a;
    logic signed [23:0]             coord_b;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [nglc_pkg::CFG_W-1:0]     cfg_data;
    logic                           done;
    logic [9:0]                     lon_index;
    logic [8:0]                     lat_index;
    logic [18:0]                    flat_index;
    logic signed [26:0]             grid_lon;
    logic signed [23:0]             grid_lat;
    int                             pending;
    int                             fail_count;

    int  cycles;
    int  burst_left;
    bit  gaps_on;
    int  lon_mirror [1024];
    bit  lon_known  [1024];
    int  lat_mirror [512];
    bit  lat_known  [512];

    int lon_cfg   [NPHASE] = '{0, 3, 120, 17, 60, 1, 64, 8, 5, 2, 30};
    int lat_cfg   [NPHASE] = '{0, 2, 60, 1, 9, 40, 64, 5, 30, 3, 20};
    int phase_len [NPHASE] = '{20, 40, 30, 30, 50, 30, 40, 40, 40, 30, 30};

    nearest_grid_cell_locator_core dut (.*);

    nglc_cell_checker cell_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("nearest_grid_cell_locator_core_tb NOT OK");
            $finish;
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int eff_count(int v, int depth);
        return (v == 0) ? 1 : ((v > depth) ? depth : v);
    endfunction

    function automatic int fold_lon(int v);
        while (v > LON_HI)
            v -= TURN;
        while (v < LON_LO)
            v += TURN;
        return v;
    endfunction

    function automatic int clip_lat(int v);
        return (v > LAT_LIM) ? LAT_LIM : ((v < -LAT_LIM) ? -LAT_LIM : v);
    endfunction

    function automatic int pick_lon(int n);
        int k;
        k = rand_between(0, n - 1);
        case (rand_between(0, 4))
            0: return rand_between(LON_LO, LON_HI);
            1: return rand_between(-360, 720) * 65536;
            2: return lon_known[k] ? lon_mirror[k] : 0;
            3: return k * (TURN / n);
            default:
                case (rand_between(0, 3))
                    0: return LON_LO;
                    1: return LON_HI;
                    2: return TURN;
                    default: return 0;
                endcase
        endcase
    endfunction

    function automatic int pick_lat(int n);
        int k;
        k = rand_between(0, n - 1);
        case (rand_between(0, 4))
            0: return rand_between(-LAT_LIM, LAT_LIM);
            1: return rand_between(-90, 90) * 65536;
            2: return lat_known[k] ? lat_mirror[k] : 0;
            3: return rand_between(LON_LO, LON_HI);   // upper bits dropped on load
            default: return rand_between(0, 1) ? LAT_LIM : -LAT_LIM;
        endcase
    endfunction

    function automatic int pick_site_lon(int n);
        int k;
        int j;
        k = rand_between(0, n - 1);
        j = rand_between(0, n - 1);
        case (rand_between(0, 4))
            0: return rand_between(LON_LO, LON_HI);
            1: return fold_lon(lon_mirror[k] + rand_between(-2, 2) + rand_between(-1, 1) * TURN);
            2: return fold_lon(lon_mirror[k] + HALF_TURN + rand_between(-1, 1));
            3: return (lon_mirror[k] + lon_mirror[j]) >>> 1;
            default:
                case (rand_between(0, 2))
                    0: return LON_LO;
                    1: return LON_HI;
                    default: return 0;
                endcase
        endcase
    endfunction

    function automatic int pick_site_lat(int n);
        int k;
        int j;
        k = rand_between(0, n - 1);
        j = rand_between(0, n - 1);
        case (rand_between(0, 3))
            0: return rand_between(-LAT_LIM, LAT_LIM);
            1: return clip_lat(lat_mirror[k] + rand_between(-2, 2));
            2: return clip_lat((lat_mirror[k] + lat_mirror[j]) >>> 1);
            default:
                case (rand_between(0, 2))
                    0: return LAT_LIM;
                    1: return -LAT_LIM;
                    default: return 0;
                endcase
        endcase
    endfunction

    task automatic send_word(logic [1:0] code, int pos, int a, int b);
        int                 gap;
        logic signed [23:0] lat24;
        if (burst_left == 0)
        begin
            burst_left = rand_between(1, 16);
            if (gaps_on)
            begin
                gap = rand_between(1, 20);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        case (code)
            nglc_pkg::OP_LOAD_LON:
            begin
                lon_mirror[pos] = a;
                lon_known[pos] = 1'b1;
            end
            nglc_pkg::OP_LOAD_LAT:
                if (pos < 512)
                begin
                    lat24 = a[23:0];
                    lat_mirror[pos] = lat24;
                    lat_known[pos] = 1'b1;
                end
            default: ;
        endcase
        op <= code;
        position <= pos[9:0];
        coord_a <= a[26:0];
        coord_b <= b[23:0];
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_counts(int lonv, int latv);
        cfg_we <= 1'b1;
        cfg_index <= nglc_pkg::CFG_LON_COUNT;
        cfg_data <= lonv[nglc_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= nglc_pkg::CFG_LAT_COUNT;
        cfg_data <= latv[nglc_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item(int nlon, int nlat);
        int r;
        int p;
        r = rand_between(0, 99);
        if (r < 45)
            send_word(nglc_pkg::OP_QUERY, rand_between(0, 1023), pick_site_lon(nlon),
                      pick_site_lat(nlat));
        else if (r < 70)
        begin
            p = (rand_between(0, 3) == 0) ? rand_between(0, 1023) : rand_between(0, nlon - 1);
            send_word(nglc_pkg::OP_LOAD_LON, p, pick_lon(nlon),
                      rand_between(-LAT_LIM, LAT_LIM));
        end
        else if (r < 92)
        begin
            p = (rand_between(0, 4) == 0) ? rand_between(0, 1023) : rand_between(0, nlat - 1);
            send_word(nglc_pkg::OP_LOAD_LAT, p, pick_lat(nlat),
                      rand_between(-LAT_LIM, LAT_LIM));
        end
        else
            send_word(OP_UNUSED, rand_between(0, 1023), rand_between(LON_LO, LON_HI),
                      rand_between(-LAT_LIM, LAT_LIM));
    endtask

    initial
    begin
        int nlon;
        int nlat;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = nglc_pkg::OP_QUERY;
        position = '0;
        coord_a = '0;
        coord_b = '0;
        cfg_we = 1'b0;
        cfg_index = nglc_pkg::CFG_LON_COUNT;
        cfg_data = '0;
        cycles = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset counts of one: single entry per axis
        send_word(nglc_pkg::OP_LOAD_LON, 0, LON_LO, 0);
        send_word(nglc_pkg::OP_LOAD_LAT, 0, -LAT_LIM, 0);
        send_word(nglc_pkg::OP_QUERY, 0, LON_HI, LAT_LIM);
        send_word(nglc_pkg::OP_QUERY, 1023, LON_LO, -LAT_LIM);
        send_word(nglc_pkg::OP_QUERY, 0, LON_LO + HALF_TURN, 0);
        send_word(OP_UNUSED, 1023, LON_HI, LAT_LIM);
        send_word(nglc_pkg::OP_LOAD_LAT, 700, 65536, 0);
        send_word(nglc_pkg::OP_QUERY, 0, 0, 0);
        send_word(nglc_pkg::OP_LOAD_LAT, 0, LON_HI, -LAT_LIM);
        send_word(nglc_pkg::OP_QUERY, 0, 0, LAT_LIM);
        send_word(nglc_pkg::OP_LOAD_LON, 0, LON_HI, 0);
        send_word(nglc_pkg::OP_QUERY, 0, LON_LO, 0);
        send_word(nglc_pkg::OP_LOAD_LON, 1023, TURN, 0);
        send_word(nglc_pkg::OP_LOAD_LAT, 511, LAT_LIM, 0);
        send_word(nglc_pkg::OP_QUERY, 512, 0, -1);

        for (int ph = 0; ph < NPHASE; ph++)
        begin
            drain();
            set_counts(lon_cfg[ph], lat_cfg[ph]);
            nlon = eff_count(lon_cfg[ph] & 'h7FF, 1024);
            nlat = eff_count(lat_cfg[ph] & 'h3FF, 512);
            gaps_on = (rand_between(0, 3) != 0);
            for (int i = 0; i < nlon; i++)
                if (!lon_known[i])
                    send_word(nglc_pkg::OP_LOAD_LON, i, pick_lon(nlon), 0);
            for (int i = 0; i < nlat; i++)
                if (!lat_known[i])
                    send_word(nglc_pkg::OP_LOAD_LAT, i, pick_lat(nlat), 0);
            repeat (phase_len[ph]) random_item(nlon, nlat);
        end

        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("nearest_grid_cell_locator_core_tb OK");
        else
            $display("nearest_grid_cell_locator_core_tb NOT OK");
        $finish;
    end

endmodule
